// File: rtl/tcse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the TLS ClientHello server name extractor.
// Depends on nothing; every other file in rtl uses it by scoped names.
package tcse_pkg;

  localparam int unsigned PKT_LEN_MAX_DEF = 65535;
  localparam int unsigned JOB_DEPTH_DEF   = 4;

  localparam logic [15:0] MAX_NAME_LEN_RST = 16'd255;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_OVERRUN  = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_UNUSABLE = 3'd4;

  typedef struct packed {
    logic        has_name;
    logic [7:0]  name_byte;
    logic        name_last;
    logic        has_sum;
    logic [2:0]  status;
    logic        is_handshake;
    logic [15:0] rec_version;
  } job_t;

endpackage

// File: rtl/tls_client_hello_sni_extractor.sv
`timescale 1ns / 1ps
// Top level of the TLS ClientHello server name extractor.
// Instantiates tcse_front, tcse_fifo and tcse_back; uses tcse_pkg.
//
// Usage: packet bytes enter through a queue-style input (push, full) with the
// packet length and a first-byte flag alongside. A byte is taken at every
// clock edge where push is high and full is low, one byte per cycle at full
// rate. Results leave through a queue-style output (empty, pop): the oldest
// result sits on the ports while empty is low and is taken when pop is high.
// A byte inside the server name gives one name transaction; the packet's last
// byte gives a summary transaction, which follows the name transaction when
// both fall on the same byte. A result is queued as its byte is taken. The
// parser updates its counters per byte, so it takes one byte per cycle while
// full is low and gives one transaction per cycle while pop is high.
// Results wait in a job queue of JOB_DEPTH entries; when the receiver stalls
// the queue fills and full rises, holding off input until space frees up.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the longest
// accepted server name and is always ready; write it only while idle.
// Synchronous reset empties the queue, restarts the parser at offset zero and
// sets the name limit to 255.
module tls_client_hello_sni_extractor #(
  parameter int unsigned PKT_LEN_MAX = tcse_pkg::PKT_LEN_MAX_DEF,
  parameter int unsigned JOB_DEPTH   = tcse_pkg::JOB_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_value,
  input  logic [15:0] pkt_len,
  input  logic        first_of_packet,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind,
  output logic [7:0]  name_byte,
  output logic        name_last,
  output logic [2:0]  status,
  output logic        is_handshake,
  output logic [15:0] rec_version,
  output logic        run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic           accept;
  logic [15:0]    max_name_len;
  logic           job_push;
  tcse_pkg::job_t job;
  tcse_pkg::job_t head;
  logic           head_empty;
  logic           head_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_len <= tcse_pkg::MAX_NAME_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_name_len <= cfg_data;
    end
  end

  tcse_front #(
    .PKT_LEN_MAX(PKT_LEN_MAX)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .byte_value(byte_value),
    .pkt_len(pkt_len),
    .first_of_packet(first_of_packet),
    .max_name_len(max_name_len),
    .job_push(job_push),
    .job(job)
  );

  tcse_fifo #(
    .DEPTH(JOB_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .wr_en(job_push),
    .wr_job(job),
    .rd_en(head_pop),
    .rd_job(head),
    .full(full),
    .empty(head_empty)
  );

  tcse_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .head_empty(head_empty),
    .head_pop(head_pop),
    .empty(empty),
    .pop(pop),
    .result_kind(result_kind),
    .name_byte(name_byte),
    .name_last(name_last),
    .status(status),
    .is_handshake(is_handshake),
    .rec_version(rec_version),
    .run_last(run_last)
  );

endmodule

// File: rtl/tcse_front.sv
`timescale 1ns / 1ps
// Parser front end: takes one byte per cycle while accept is high, walks the
// ClientHello and makes one job per byte that causes results; uses tcse_pkg.
module tcse_front #(
  parameter int unsigned PKT_LEN_MAX = tcse_pkg::PKT_LEN_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        byte_value,
  input  logic [15:0]       pkt_len,
  input  logic              first_of_packet,
  input  logic [15:0]       max_name_len,
  output logic              job_push,
  output tcse_pkg::job_t    job
);

  typedef enum logic [12:0] {
    PH_HDR       = 13'b0000000000001,
    PH_SID_LEN   = 13'b0000000000010,
    PH_SKIP_SID  = 13'b0000000000100,
    PH_CS_LEN    = 13'b0000000001000,
    PH_SKIP_CS   = 13'b0000000010000,
    PH_CM_LEN    = 13'b0000000100000,
    PH_SKIP_CM   = 13'b0000001000000,
    PH_EXT_TOTAL = 13'b0000010000000,
    PH_EXT_HDR   = 13'b0000100000000,
    PH_SKIP_EXT  = 13'b0001000000000,
    PH_SNI_HDR   = 13'b0010000000000,
    PH_NAME      = 13'b0100000000000,
    PH_DONE      = 13'b1000000000000
  } phase_t;

  localparam logic [15:0] LEN_CAP = 16'(PKT_LEN_MAX);
  localparam logic [15:0] BODY_LAST_HDR = 16'd42;

  logic [15:0] byte_pos, byte_pos_next;
  phase_t      phase, phase_next;
  logic [15:0] skip_count, skip_count_next;
  logic [15:0] field_accum, field_accum_next;
  logic [15:0] ext_code, ext_code_next;
  logic [15:0] ext_len, ext_len_next;
  logic [15:0] name_len, name_len_next;
  logic [23:0] header_bytes, header_bytes_next;
  logic [2:0]  final_status, final_status_next;

  logic [15:0] cur_pos, cur_skip, cur_accum, cur_type, cur_elen, cur_nlen;
  phase_t      cur_phase;
  logic [23:0] cur_hdr;
  logic [2:0]  cur_status;

  logic [15:0] len, rem, sc, acc;
  logic        active;
  logic        do_enter, do_skip;
  phase_t      ent_ph, skip_ph, after_ph;
  logic [15:0] skip_cnt;
  logic [15:0] need;
  logic [2:0]  fail;
  logic        name_out;
  logic        name_last_out;
  logic [7:0]  b0, b1, b2;

  always_comb begin
    if (first_of_packet) begin
      cur_pos    = '0;
      cur_phase  = PH_HDR;
      cur_skip   = '0;
      cur_accum  = '0;
      cur_type   = '0;
      cur_elen   = '0;
      cur_nlen   = '0;
      cur_hdr    = '0;
      cur_status = tcse_pkg::ST_NONE;
    end else begin
      cur_pos    = byte_pos;
      cur_phase  = phase;
      cur_skip   = skip_count;
      cur_accum  = field_accum;
      cur_type   = ext_code;
      cur_elen   = ext_len;
      cur_nlen   = name_len;
      cur_hdr    = header_bytes;
      cur_status = final_status;
    end

    len    = (pkt_len > LEN_CAP) ? LEN_CAP : pkt_len;
    active = cur_pos < len;
    rem    = len - 16'd1 - cur_pos;

    byte_pos_next     = (cur_pos != 16'hFFFF) ? cur_pos + 16'd1 : cur_pos;
    phase_next        = cur_phase;
    skip_count_next   = cur_skip;
    field_accum_next  = cur_accum;
    ext_code_next     = cur_type;
    ext_len_next      = cur_elen;
    name_len_next     = cur_nlen;
    header_bytes_next = cur_hdr;
    final_status_next = cur_status;

    do_enter = 1'b0;
    do_skip  = 1'b0;
    ent_ph   = PH_HDR;
    skip_ph  = PH_SKIP_SID;
    after_ph = PH_CS_LEN;
    skip_cnt = '0;
    name_out = 1'b0;
    name_last_out = 1'b0;
    sc  = '0;
    acc = '0;

    if (active) begin
      case (cur_phase)
        PH_HDR: begin
          if (cur_pos == 16'd0) header_bytes_next[23:16] = byte_value;
          if (cur_pos == 16'd1) header_bytes_next[15:8] = byte_value;
          if (cur_pos == 16'd2) header_bytes_next[7:0] = byte_value;
          if (cur_pos >= BODY_LAST_HDR) begin
            do_enter = 1'b1;
            ent_ph   = PH_SID_LEN;
          end
        end
        PH_SID_LEN, PH_CM_LEN: begin
          if (rem < {8'd0, byte_value}) begin
            phase_next        = PH_DONE;
            final_status_next = tcse_pkg::ST_TRUNC;
          end else begin
            do_skip  = 1'b1;
            skip_cnt = {8'd0, byte_value};
            if (cur_phase == PH_SID_LEN) begin
              skip_ph  = PH_SKIP_SID;
              after_ph = PH_CS_LEN;
            end else begin
              skip_ph  = PH_SKIP_CM;
              after_ph = PH_EXT_TOTAL;
            end
          end
        end
        PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_CM, PH_SKIP_EXT: begin
          sc = (cur_skip != 16'd0) ? cur_skip - 16'd1 : cur_skip;
          skip_count_next = sc;
          if (sc == 16'd0) begin
            do_enter = 1'b1;
            if (cur_phase == PH_SKIP_SID) ent_ph = PH_CS_LEN;
            else if (cur_phase == PH_SKIP_CS) ent_ph = PH_CM_LEN;
            else if (cur_phase == PH_SKIP_CM) ent_ph = PH_EXT_TOTAL;
            else ent_ph = PH_EXT_HDR;
          end
        end
        PH_CS_LEN, PH_EXT_TOTAL: begin
          acc = {cur_accum[7:0], byte_value};
          sc  = cur_skip + 16'd1;
          field_accum_next = acc;
          skip_count_next  = sc;
          if (sc >= 16'd2) begin
            if (cur_phase == PH_CS_LEN) begin
              if (rem < acc) begin
                phase_next        = PH_DONE;
                final_status_next = tcse_pkg::ST_TRUNC;
              end else begin
                do_skip  = 1'b1;
                skip_cnt = acc;
                skip_ph  = PH_SKIP_CS;
                after_ph = PH_CM_LEN;
              end
            end else begin
              if (acc > rem) begin
                phase_next        = PH_DONE;
                final_status_next = tcse_pkg::ST_OVERRUN;
              end else begin
                do_enter = 1'b1;
                ent_ph   = PH_EXT_HDR;
              end
            end
          end
        end
        PH_EXT_HDR: begin
          if (cur_skip < 16'd2) ext_code_next = {cur_type[7:0], byte_value};
          else ext_len_next = {cur_elen[7:0], byte_value};
          sc = cur_skip + 16'd1;
          skip_count_next = sc;
          if (sc >= 16'd4) begin
            if (rem < ext_len_next) begin
              phase_next        = PH_DONE;
              final_status_next = tcse_pkg::ST_OVERRUN;
            end else if (ext_code_next == 16'd0) begin
              if (ext_len_next < 16'd5) begin
                phase_next        = PH_DONE;
                final_status_next = tcse_pkg::ST_UNUSABLE;
              end else begin
                phase_next      = PH_SNI_HDR;
                skip_count_next = '0;
                name_len_next   = '0;
              end
            end else begin
              do_skip  = 1'b1;
              skip_cnt = ext_len_next;
              skip_ph  = PH_SKIP_EXT;
              after_ph = PH_EXT_HDR;
            end
          end
        end
        PH_SNI_HDR: begin
          if (cur_skip >= 16'd3) name_len_next = {cur_nlen[7:0], byte_value};
          sc = cur_skip + 16'd1;
          skip_count_next = sc;
          if (sc >= 16'd5) begin
            if (name_len_next != 16'd0 && name_len_next <= max_name_len &&
                {1'b0, ext_len} >= 17'd5 + {1'b0, name_len_next}) begin
              phase_next      = PH_NAME;
              skip_count_next = name_len_next;
            end else begin
              phase_next        = PH_DONE;
              final_status_next = tcse_pkg::ST_UNUSABLE;
            end
          end
        end
        PH_NAME: begin
          name_out      = 1'b1;
          name_last_out = cur_skip <= 16'd1;
          sc = (cur_skip != 16'd0) ? cur_skip - 16'd1 : cur_skip;
          skip_count_next = sc;
          if (sc == 16'd0) begin
            phase_next        = PH_DONE;
            final_status_next = tcse_pkg::ST_FOUND;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_skip) begin
      if (skip_cnt == 16'd0) begin
        do_enter = 1'b1;
        ent_ph   = after_ph;
      end else begin
        phase_next      = skip_ph;
        skip_count_next = skip_cnt;
      end
    end

    need = 16'd2;
    fail = tcse_pkg::ST_TRUNC;
    if (ent_ph == PH_CM_LEN) need = 16'd1;
    if (ent_ph == PH_EXT_HDR) begin
      need = 16'd4;
      fail = tcse_pkg::ST_NONE;
    end
    if (do_enter) begin
      if (rem < need) begin
        phase_next        = PH_DONE;
        final_status_next = fail;
      end else begin
        phase_next       = ent_ph;
        skip_count_next  = '0;
        field_accum_next = '0;
      end
    end
  end

  assign b0 = header_bytes_next[23:16];
  assign b1 = header_bytes_next[15:8];
  assign b2 = header_bytes_next[7:0];

  always_comb begin
    job.has_name     = name_out;
    job.name_byte    = name_out ? byte_value : 8'd0;
    job.name_last    = name_last_out;
    job.has_sum      = active && (rem == 16'd0);
    job.status       = (phase_next == PH_DONE) ? final_status_next : tcse_pkg::ST_TRUNC;
    job.is_handshake = (len >= 16'd6) && (b0 == 8'h16) && (b1 == 8'h03) &&
                       (b2 >= 8'd1) && (b2 <= 8'd4);
    job.rec_version  = (len >= 16'd3) ? {b1, b2} : 16'd0;
  end

  assign job_push = accept && (job.has_name || job.has_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos     <= '0;
      phase        <= PH_HDR;
      skip_count   <= '0;
      field_accum  <= '0;
      ext_code     <= '0;
      ext_len      <= '0;
      name_len     <= '0;
      header_bytes <= '0;
      final_status <= tcse_pkg::ST_NONE;
    end else if (accept) begin
      byte_pos     <= byte_pos_next;
      phase        <= phase_next;
      skip_count   <= skip_count_next;
      field_accum  <= field_accum_next;
      ext_code     <= ext_code_next;
      ext_len      <= ext_len_next;
      name_len     <= name_len_next;
      header_bytes <= header_bytes_next;
      final_status <= final_status_next;
    end
  end

endmodule

// File: rtl/tcse_fifo.sv
`timescale 1ns / 1ps
// Short job queue between the parser front end and the result sequencer.
// Uses tcse_pkg for the job type.
module tcse_fifo #(
  parameter int unsigned DEPTH = tcse_pkg::JOB_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  tcse_pkg::job_t wr_job,
  input  logic           rd_en,
  output tcse_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tcse_pkg::job_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr, do_rd;

  assign full  = count == FULL_CNT;
  assign empty = count == '0;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

// File: rtl/tcse_back.sv
`timescale 1ns / 1ps
// Result sequencer: turns each queued job into one or two result transactions,
// the name byte first and the summary after it. Uses tcse_pkg.
module tcse_back (
  input  logic           clk,
  input  logic           rst,
  input  tcse_pkg::job_t head,
  input  logic           head_empty,
  output logic           head_pop,
  output logic           empty,
  input  logic           pop,
  output logic           result_kind,
  output logic [7:0]     name_byte,
  output logic           name_last,
  output logic [2:0]     status,
  output logic           is_handshake,
  output logic [15:0]    rec_version,
  output logic           run_last
);

  logic sub;
  logic show_sum;
  logic taken;

  assign show_sum = !head.has_name || sub;
  assign taken    = pop && !head_empty;
  assign empty    = head_empty;

  assign result_kind  = show_sum;
  assign name_byte    = show_sum ? 8'd0 : head.name_byte;
  assign name_last    = show_sum ? 1'b0 : head.name_last;
  assign status       = show_sum ? head.status : tcse_pkg::ST_FOUND;
  assign is_handshake = show_sum ? head.is_handshake : 1'b0;
  assign rec_version  = show_sum ? head.rec_version : 16'd0;
  assign run_last     = show_sum || !head.has_sum;
  assign head_pop     = taken && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (taken) begin
      sub <= !run_last;
    end
  end

endmodule
